/* hw/rtl/ncm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ncm_pkg;

    // fixed-point widths
    localparam int LIN_W  = 25;   // linear light, Q24, up to 1.0
    localparam int SUM_W  = 38;   // matrix sums before normalization
    localparam int NUM_W  = 42;   // divider dividend
    localparam int DEN_W  = 17;   // divider divisor
    localparam int F_W    = 26;   // lab f() values, Q24
    localparam int LAB_W  = 16;   // one Lab component, 1/16 units
    localparam int DIST_W = 26;   // reported squared distance

    // opcodes carried in s_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // divisors of the normalization and the linear f() branch, the f() threshold and offset
    localparam logic [DEN_W-1:0] DEN_X   = DEN_W'(95047);
    localparam logic [DEN_W-1:0] DEN_Y   = DEN_W'(10000);
    localparam logic [DEN_W-1:0] DEN_Z   = DEN_W'(108883);
    localparam logic [DEN_W-1:0] DEN_LIN = DEN_W'(1000);
    localparam longint unsigned F_THR_L  = (64'd8856 << 24) / 64'd1000000;
    localparam longint unsigned F_OFS_L  = ((64'd16 << 24) + 64'd58) / 64'd116;
    localparam logic [F_W-1:0] F_THR     = F_W'(F_THR_L);
    localparam logic [F_W-1:0] F_OFS     = F_W'(F_OFS_L);

    // reciprocals for the constant divides: q ~ ((n >> S) * floor(2^(S+K)/d)) >> K,
    // the estimate never exceeds the quotient and is at most one below it
    localparam int RCP_K    = 38;
    localparam int RCP_SX   = 10;
    localparam int RCP_SY   = 7;
    localparam int RCP_SZ   = 10;
    localparam logic [31:0] RCP_X   = 32'((64'd1 << (RCP_K + RCP_SX)) / 64'(DEN_X));
    localparam logic [31:0] RCP_Y   = 32'((64'd1 << (RCP_K + RCP_SY)) / 64'(DEN_Y));
    localparam logic [31:0] RCP_Z   = 32'((64'd1 << (RCP_K + RCP_SZ)) / 64'(DEN_Z));
    localparam logic [31:0] RCP_LIN = 32'((64'd1 << RCP_K) / 64'(DEN_LIN));

    typedef logic [LIN_W-1:0] gamma_tab_t [256];

    // fifth power with truncated Q30 products
    function automatic longint unsigned pow5_q30(input longint unsigned r);
        longint unsigned m2;
        longint unsigned m4;
        m2 = (r * r) >> 30;
        m4 = (m2 * m2) >> 30;
        return (m4 * r) >> 30;
    endfunction

    // srgb gamma expansion of one 8-bit code, Q24
    function automatic logic [LIN_W-1:0] gamma_q24(input longint unsigned c);
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        longint unsigned cand;
        longint unsigned lin;
        r = 0;
        if (c * 64'd100000 <= 64'd1031475)
            return LIN_W'((c * 64'd100 * (64'd1 << 24) + 64'd164730) / 64'd329460);
        t = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        s = (t * t) >> 30;
        for (int b = 30; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (cand <= (64'd1 << 30) && pow5_q30(cand) <= s)
                r = cand;
        end
        lin = (s * r) >> 30;
        return LIN_W'((lin + 64'd32) >> 6);
    endfunction

    function automatic gamma_tab_t build_gamma();
        gamma_tab_t tab;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = gamma_q24(longint'(i));
        end
        return tab;
    endfunction

    localparam gamma_tab_t GAMMA_TAB = build_gamma();

    // clamp to the signed 16-bit range
    function automatic logic signed [LAB_W-1:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)
            return 16'sh7fff;
        if (v < -48'sd32768)
            return 16'sh8000;
        return v[LAB_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ncm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ncm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/nearest_color_cielab_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none

// Nearest palette color matcher. Each transaction on the s_ side carries an 8-bit RGB
// triple and an opcode in tuser: 0 converts it to CIELAB (sRGB, D65) and stores it in
// palette slot entry_index (slots at or beyond ENTRIES are ignored), 1 converts it and
// returns on the m_ side the lowest slot index with the least squared Lab distance,
// saturated to 26 bits. Items are handled one at a time; s_tready is high only while
// the block is idle. For each of X, Y and Z the matrix sum is normalized by a
// reciprocal multiply with at most one correction step, then f() takes either a
// cube-root search (a square step and a cube-and-compare step per root bit) or a
// second divide, followed by the Lab stage. A load then writes the palette and
// returns to idle. A query scans the palette memory at one read per cycle through
// read, square and sum-and-compare registers, then hands over its result once the
// output is free. A finished result waits in an output register while the next
// item is taken; the next result is held back until that one has been taken.
// Querying a slot never loaded gives an undefined answer.
module nearest_color_cielab_matcher #(
    parameter int ENTRIES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // entry_index[5:0], red, green, blue, zero pad
    input  wire logic [0:0]  s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // color_index[5:0], distance_sq[25:0]
);

    import ncm_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = 3 * LAB_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MAT  = 4'd1;
    localparam logic [3:0] ST_DSET = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_CUBA = 4'd4;
    localparam logic [3:0] ST_CUBB = 4'd5;
    localparam logic [3:0] ST_LAB  = 4'd6;
    localparam logic [3:0] ST_WR   = 4'd7;
    localparam logic [3:0] ST_SCAN = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;
    localparam logic [3:0] ST_DMUL = 4'd10;
    localparam logic [3:0] ST_DREM = 4'd11;

    logic [3:0]             state_reg, state_next;
    logic                   op_reg;
    logic [5:0]             idx_reg;
    logic [LIN_W-1:0]       lin_reg [3];
    logic [SUM_W-1:0]       sum_reg [3];
    logic [F_W-1:0]         f_reg [3];
    logic [1:0]             ch_reg;
    logic                   lin_phase_reg;
    logic [F_W-1:0]         v_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [31:0]            nh_reg;
    logic [31:0]            rcp_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [NUM_W-1:0]       rem_reg;
    logic [F_W-1:0]         quo_reg;
    logic [F_W-1:0]         root_reg;
    logic [4:0]             bit_reg;
    logic [27:0]            sq_reg;
    logic [EW-1:0]          lab_reg;
    logic [CW-1:0]          addr_reg;
    logic                   rd_v_reg;
    logic [IW-1:0]          rd_i_reg;
    logic                   sq_v_reg;
    logic [IW-1:0]          sq_i_reg;
    logic [33:0]            d2_reg [3];
    logic [34:0]            best_d_reg;
    logic [IW-1:0]          best_i_reg;
    logic                   m_tvalid_reg;
    logic [31:0]            m_data_reg;

    logic                   ram_we;
    logic                   ram_re;
    logic [EW-1:0]          ram_rdata;

    // divider step
    logic [63:0]            rcp_prod;
    logic [F_W-1:0]         quo_est;
    logic [NUM_W-1:0]       quo_den;
    logic                   div_done;
    logic [NUM_W-1:0]       num_sel;
    logic [31:0]            nh_sel;
    logic [31:0]            rcp_sel;
    logic [DEN_W-1:0]       den_sel;

    // cube root step
    logic [F_W-1:0]         cand;
    logic [51:0]            cand_sq;
    logic [53:0]            cand_cube;
    logic                   cube_ok;

    // lab outputs
    logic signed [47:0]     fxs, fys, fzs;
    logic signed [LAB_W-1:0] lab_l, lab_a, lab_b;

    // scan distance
    logic signed [16:0]     dl, da, db;
    logic [34:0]            d_sum;
    logic                   scan_end;
    logic                   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // divider datapath: reciprocal estimate, remainder, one correction
    assign rcp_prod = 64'(nh_reg) * 64'(rcp_reg);
    assign quo_est  = F_W'(rcp_prod >> RCP_K);
    assign quo_den  = NUM_W'(quo_reg) * NUM_W'(den_reg);
    assign div_done = rem_reg < NUM_W'(den_reg);

    // dividend for the current channel and phase
    always_comb
    begin
        if (lin_phase_reg)
        begin
            num_sel = NUM_W'(v_reg) * NUM_W'(7787) + NUM_W'(500);
            nh_sel  = num_sel[31:0];
            rcp_sel = RCP_LIN;
            den_sel = DEN_LIN;
        end
        else
        begin
            case (ch_reg)
                2'd0:
                begin
                    num_sel = NUM_W'(sum_reg[0]) * NUM_W'(10) + NUM_W'(47523);
                    nh_sel  = 32'(num_sel >> RCP_SX);
                    rcp_sel = RCP_X;
                    den_sel = DEN_X;
                end
                2'd1:
                begin
                    num_sel = NUM_W'(sum_reg[1]) + NUM_W'(5000);
                    nh_sel  = 32'(num_sel >> RCP_SY);
                    rcp_sel = RCP_Y;
                    den_sel = DEN_Y;
                end
                default:
                begin
                    num_sel = NUM_W'(sum_reg[2]) * NUM_W'(10) + NUM_W'(54441);
                    nh_sel  = 32'(num_sel >> RCP_SZ);
                    rcp_sel = RCP_Z;
                    den_sel = DEN_Z;
                end
            endcase
        end
    end

    // cube root datapath, one multiply per cycle
    assign cand      = root_reg | (F_W'(1) << bit_reg);
    assign cand_sq   = 52'(cand) * 52'(cand);
    assign cand_cube = 54'(sq_reg) * 54'(cand);
    assign cube_ok   = (cand_cube >> 24) <= 54'(v_reg);

    // lab from f values
    assign fxs   = $signed({22'b0, f_reg[0]});
    assign fys   = $signed({22'b0, f_reg[1]});
    assign fzs   = $signed({22'b0, f_reg[2]});
    assign lab_l = sat16(((48'sd1856 * fys + 48'sd8388608) >>> 24) - 48'sd256);
    assign lab_a = sat16((48'sd8000 * (fxs - fys) + 48'sd8388608) >>> 24);
    assign lab_b = sat16((48'sd3200 * (fys - fzs) + 48'sd8388608) >>> 24);

    // palette memory
    assign ram_we = (state_reg == ST_WR) && ({3'b0, idx_reg} < 9'(ENTRIES));
    assign ram_re = (state_reg == ST_SCAN) && (addr_reg < CW'(ENTRIES));

    ncm_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IW'(idx_reg)),
        .wdata (lab_reg),
        .re    (ram_re),
        .raddr (addr_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    // distance terms
    assign dl = 17'(signed'(ram_rdata[15:0]))  - 17'(signed'(lab_reg[15:0]));
    assign da = 17'(signed'(ram_rdata[31:16])) - 17'(signed'(lab_reg[31:16]));
    assign db = 17'(signed'(ram_rdata[47:32])) - 17'(signed'(lab_reg[47:32]));
    assign d_sum = 35'(d2_reg[0]) + 35'(d2_reg[1]) + 35'(d2_reg[2]);
    assign scan_end = (addr_reg == CW'(ENTRIES)) && !rd_v_reg && !sq_v_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MAT;
            ST_MAT:  state_next = ST_DSET;
            ST_DSET: state_next = ST_DMUL;
            ST_DMUL: state_next = ST_DREM;
            ST_DREM: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (!lin_phase_reg && quo_reg > F_THR)
                        state_next = ST_CUBA;
                    else if (!lin_phase_reg)
                        state_next = ST_DSET;
                    else if (ch_reg == 2'd2)
                        state_next = ST_LAB;
                    else
                        state_next = ST_DSET;
                end
            end
            ST_CUBA: state_next = ST_CUBB;
            ST_CUBB:
            begin
                if (bit_reg != 5'd0)
                    state_next = ST_CUBA;
                else if (ch_reg == 2'd2)
                    state_next = ST_LAB;
                else
                    state_next = ST_DSET;
            end
            ST_LAB:  state_next = (op_reg == OP_LOAD) ? ST_WR : ST_SCAN;
            ST_WR:   state_next = ST_IDLE;
            ST_SCAN: if (scan_end) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            rd_v_reg     <= 1'b0;
            sq_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= ram_re;
            sq_v_reg  <= rd_v_reg;
            if (state_reg == ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg        <= s_tuser[0];
                idx_reg       <= s_tdata[5:0];
                lin_reg[0]    <= GAMMA_TAB[s_tdata[13:6]];
                lin_reg[1]    <= GAMMA_TAB[s_tdata[21:14]];
                lin_reg[2]    <= GAMMA_TAB[s_tdata[29:22]];
                ch_reg        <= 2'd0;
                lin_phase_reg <= 1'b0;
                addr_reg      <= '0;
            end
            ST_MAT:
            begin
                sum_reg[0] <= SUM_W'(lin_reg[0]) * SUM_W'(4124)
                            + SUM_W'(lin_reg[1]) * SUM_W'(3576)
                            + SUM_W'(lin_reg[2]) * SUM_W'(1805);
                sum_reg[1] <= SUM_W'(lin_reg[0]) * SUM_W'(2126)
                            + SUM_W'(lin_reg[1]) * SUM_W'(7152)
                            + SUM_W'(lin_reg[2]) * SUM_W'(722);
                sum_reg[2] <= SUM_W'(lin_reg[0]) * SUM_W'(193)
                            + SUM_W'(lin_reg[1]) * SUM_W'(1192)
                            + SUM_W'(lin_reg[2]) * SUM_W'(9505);
            end
            ST_DSET:
            begin
                num_reg <= num_sel;
                nh_reg  <= nh_sel;
                rcp_reg <= rcp_sel;
                den_reg <= den_sel;
            end
            ST_DMUL:
            begin
                quo_reg <= quo_est;
            end
            ST_DREM:
            begin
                rem_reg <= num_reg - quo_den;
            end
            ST_DIV:
            begin
                if (!div_done)
                begin
                    rem_reg <= rem_reg - NUM_W'(den_reg);
                    quo_reg <= quo_reg + F_W'(1);
                end
                else
                begin
                    if (!lin_phase_reg)
                    begin
                        v_reg <= quo_reg;
                        if (quo_reg > F_THR)
                        begin
                            root_reg <= '0;
                            bit_reg  <= 5'd24;
                        end
                        else
                        begin
                            lin_phase_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        f_reg[ch_reg] <= quo_reg + F_OFS;
                        lin_phase_reg <= 1'b0;
                        ch_reg        <= ch_reg + 2'd1;
                    end
                end
            end
            ST_CUBA:
            begin
                sq_reg <= cand_sq[51:24];
            end
            ST_CUBB:
            begin
                if (cube_ok)
                    root_reg <= cand;
                if (bit_reg != 5'd0)
                begin
                    bit_reg <= bit_reg - 5'd1;
                end
                else
                begin
                    f_reg[ch_reg] <= cube_ok ? cand : root_reg;
                    ch_reg        <= ch_reg + 2'd1;
                end
            end
            ST_LAB:
            begin
                lab_reg <= {lab_b, lab_a, lab_l};
            end
            ST_SCAN:
            begin
                if (ram_re)
                    addr_reg <= addr_reg + CW'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                    m_data_reg <= {(best_d_reg > 35'(2 ** DIST_W - 1))
                                   ? {DIST_W{1'b1}} : best_d_reg[DIST_W-1:0],
                                   6'(best_i_reg)};
            end
            default:
            begin
            end
        endcase

        // scan pipeline: squares, then sum and compare
        rd_i_reg <= addr_reg[IW-1:0];
        if (rd_v_reg)
        begin
            d2_reg[0] <= 34'(dl) * 34'(dl);
            d2_reg[1] <= 34'(da) * 34'(da);
            d2_reg[2] <= 34'(db) * 34'(db);
            sq_i_reg  <= rd_i_reg;
        end
        if (sq_v_reg && (sq_i_reg == '0 || d_sum < best_d_reg))
        begin
            best_d_reg <= d_sum;
            best_i_reg <= sq_i_reg;
        end
    end

    // checks
    a_write_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_WR) && (op_reg == OP_LOAD))
        else $error("palette written outside a load");

    a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (state_reg == ST_SCAN))
        else $error("palette read outside a scan");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised without a finished scan");

    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !rd_v_reg && !sq_v_reg)
        else $error("scan finished with reads in flight");

endmodule

`default_nettype wire
